FILE: hdl/fcos_pkg.sv
// Package for the single-precision cosine pipeline: constants, stage type, float arithmetic.
package fcos_pkg;

  localparam int NumStages = 17;

  localparam logic [31:0] FltFopi = 32'h3FA2F983;
  localparam logic [31:0] FltDp1  = 32'hBF490000;
  localparam logic [31:0] FltDp2  = 32'hB97DA000;
  localparam logic [31:0] FltDp3  = 32'hB3222169;
  localparam logic [31:0] FltS0   = 32'hB94CA1F9;
  localparam logic [31:0] FltS1   = 32'h3C08839E;
  localparam logic [31:0] FltS2   = 32'hBE2AAAA3;
  localparam logic [31:0] FltC0   = 32'h37CCF5CE;
  localparam logic [31:0] FltC1   = 32'hBAB6061A;
  localparam logic [31:0] FltC2   = 32'h3D2AAAA5;
  localparam logic [31:0] FltHalf = 32'h3F000000;
  localparam logic [31:0] FltOne  = 32'h3F800000;
  localparam logic [31:0] FltZero = 32'h00000000;
  localparam logic [31:0] FltDefNan = 32'hFFC00000;
  localparam logic [30:0] OvfBits = 31'h4F000000;
  localparam logic [31:0] IntIndef = 32'h80000000;

  typedef struct packed {
    logic        ovf;
    logic        sgn;
    logic        use_sin;
    logic [31:0] j;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [31:0] h;
    logic [31:0] c;
    logic [31:0] s;
  } stage_t;

  function automatic logic is_nan(input logic [31:0] a);
    return (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
  endfunction

  function automatic logic is_inf(input logic [31:0] a);
    return (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
  endfunction

  function automatic logic [5:0] clz48(input logic [47:0] p);
    logic [5:0] lz;
    lz = 6'd0;
    for (int i = 0; i < 48; i++) begin
      if (p[i]) lz = 6'(47 - i);
    end
    return lz;
  endfunction

  function automatic logic [31:0] round_pack(input logic sgn, input logic signed [11:0] e,
                                             input logic [47:0] p, input logic st_in);
    logic [47:0] q;
    logic [7:0]  ef;
    logic [11:0] sh;
    logic [23:0] m;
    logic        st;
    logic        inc;
    logic [30:0] mag;
    q  = p;
    ef = e[7:0];
    st = st_in;
    sh = 12'd0;
    if (e >= 12'sd255) return {sgn, 8'hFF, 23'd0};
    if (e < 12'sd1) begin
      sh = 12'(12'sd1 - e);
      ef = 8'd0;
      if (sh >= 12'd48) begin
        st = st | (|q);
        q  = 48'd0;
      end else begin
        st = st | (|(q & ~({48{1'b1}} << sh[5:0])));
        q  = q >> sh[5:0];
      end
    end
    m   = q[47:24];
    st  = st | (|q[22:0]);
    inc = q[23] & (st | m[0]);
    mag = {ef, m[22:0]} + 31'(inc);
    return {sgn, mag};
  endfunction

  function automatic logic [31:0] fmul(input logic [31:0] a, input logic [31:0] b);
    logic               sg;
    logic [23:0]        ma, mb;
    logic signed [11:0] ea, eb, e;
    logic [47:0]        p;
    logic [5:0]         lz;
    sg = a[31] ^ b[31];
    if (is_nan(a)) return a | 32'h00400000;
    if (is_nan(b)) return b | 32'h00400000;
    if (is_inf(a)) return (b[30:0] == 31'd0) ? FltDefNan : {sg, 8'hFF, 23'd0};
    if (is_inf(b)) return (a[30:0] == 31'd0) ? FltDefNan : {sg, 8'hFF, 23'd0};
    if ((a[30:0] == 31'd0) || (b[30:0] == 31'd0)) return {sg, 31'd0};
    ma = {(a[30:23] != 8'd0), a[22:0]};
    mb = {(b[30:23] != 8'd0), b[22:0]};
    ea = (a[30:23] == 8'd0) ? 12'sd1 : $signed({4'd0, a[30:23]});
    eb = (b[30:23] == 8'd0) ? 12'sd1 : $signed({4'd0, b[30:23]});
    p  = ma * mb;
    lz = clz48(p);
    p  = p << lz;
    e  = ea + eb - 12'sd126 - $signed({6'd0, lz});
    return round_pack(sg, e, p, 1'b0);
  endfunction

  function automatic logic [31:0] fadd(input logic [31:0] a, input logic [31:0] b);
    logic [31:0]        x, y;
    logic [23:0]        mx, my;
    logic [26:0]        my27, myal;
    logic [7:0]         d;
    logic signed [11:0] ex, e;
    logic [7:0]         exu, eyu;
    logic               sub;
    logic [27:0]        sum;
    logic [47:0]        p;
    logic [5:0]         lz;
    if (is_nan(a)) return a | 32'h00400000;
    if (is_nan(b)) return b | 32'h00400000;
    if (is_inf(a) && is_inf(b) && (a[31] != b[31])) return FltDefNan;
    if (is_inf(a)) return a;
    if (is_inf(b)) return b;
    if (b[30:0] > a[30:0]) begin
      x = b;
      y = a;
    end else begin
      x = a;
      y = b;
    end
    mx   = {(x[30:23] != 8'd0), x[22:0]};
    my   = {(y[30:23] != 8'd0), y[22:0]};
    exu  = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
    eyu  = (y[30:23] == 8'd0) ? 8'd1 : y[30:23];
    d    = exu - eyu;
    ex   = $signed({4'd0, exu});
    my27 = {my, 3'd0};
    if (d >= 8'd27) begin
      myal = {26'd0, (my != 24'd0)};
    end else begin
      myal = (my27 >> d[4:0]) | {26'd0, |(my27 & ~({27{1'b1}} << d[4:0]))};
    end
    sub = x[31] ^ y[31];
    sum = sub ? ({1'b0, mx, 3'd0} - {1'b0, myal}) : ({1'b0, mx, 3'd0} + {1'b0, myal});
    if (sum == 28'd0) return sub ? FltZero : {x[31], 31'd0};
    p  = {sum, 20'd0};
    lz = clz48(p);
    p  = p << lz;
    e  = ex + 12'sd1 - $signed({6'd0, lz});
    return round_pack(x[31], e, p, 1'b0);
  endfunction

  function automatic logic [31:0] fsub(input logic [31:0] a, input logic [31:0] b);
    return fadd(a, is_nan(b) ? b : {~b[31], b[30:0]});
  endfunction

  function automatic logic [31:0] ftrunc(input logic [31:0] y);
    logic [31:0] m;
    m = {8'd0, 1'b1, y[22:0]};
    if (y[30:23] < 8'd127) return 32'd0;
    if (y[30:23] >= 8'd150) return m << (y[30:23] - 8'd150);
    return m >> (8'd150 - y[30:23]);
  endfunction

  function automatic logic [31:0] i2f(input logic [31:0] j);
    logic [31:0] mag;
    logic [47:0] p;
    logic [5:0]  lz;
    mag = j[31] ? (~j + 32'd1) : j;
    if (mag == 32'd0) return FltZero;
    p  = {mag, 16'd0};
    lz = clz48(p);
    p  = p << lz;
    return round_pack(j[31], 12'sd158 - $signed({6'd0, lz}), p, 1'b0);
  endfunction

endpackage

FILE: hdl/float_cosine_core.sv
// Single-precision cosine pipeline, one angle per cycle.
//
//  channel   dir  signals                 content
//  s_axis    in   tvalid tready tdata     tdata[31:0] angle_bits
//  m_axis    out  tvalid tready tdata     tdata[31:0] cosine_bits
//                 tuser                   tuser[0] range_flag
//
// One request per cycle is taken while m_axis is not stalled; each result passes
// the input register and then 17 arithmetic stages, and leaves from the last of
// them. rst clears only the stage valid bits. A stall on
// m_axis freezes the whole pipeline and drops s_axis_tready while the
// output stage holds a result.
module float_cosine_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] angle_bits
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] cosine_bits
  output logic [0:0]  m_axis_tuser    // [0] range_flag
);
  import fcos_pkg::*;

  stage_t st  [0:NumStages];
  stage_t nx  [1:NumStages];
  logic   vld [0:NumStages];
  logic   ce;
  logic [31:0] t;

  assign ce            = !vld[NumStages] || m_axis_tready;
  assign s_axis_tready = ce;
  assign m_axis_tvalid = vld[NumStages];
  assign m_axis_tdata  = st[NumStages].c;
  assign m_axis_tuser  = st[NumStages].ovf;

  always_comb begin
    t = 32'd0;
    for (int k = 1; k <= NumStages; k++) begin
      nx[k] = st[k-1];
      case (k)
        1: begin
          nx[k].y   = fmul(st[k-1].x, FltFopi);
          nx[k].ovf = (nx[k].y[30:0] >= OvfBits);
        end
        2: begin
          nx[k].j = (st[k-1].ovf ? IntIndef : ftrunc(st[k-1].y)) + 32'd1;
          nx[k].j[0] = 1'b0;
          t = nx[k].j - 32'd2;
          nx[k].sgn     = ~t[2];
          nx[k].use_sin = ~t[1];
        end
        3: nx[k].y = i2f(st[k-1].j);
        4: begin
          nx[k].z = fmul(st[k-1].y, FltDp1);
          nx[k].h = fmul(st[k-1].y, FltDp2);
          nx[k].c = fmul(st[k-1].y, FltDp3);
        end
        5: nx[k].x = fadd(st[k-1].x, st[k-1].z);
        6: nx[k].x = fadd(st[k-1].x, st[k-1].h);
        7: nx[k].x = fadd(st[k-1].x, st[k-1].c);
        8: nx[k].z = fmul(st[k-1].x, st[k-1].x);
        9: begin
          nx[k].c = fmul(FltC0, st[k-1].z);
          nx[k].s = fmul(FltS0, st[k-1].z);
          nx[k].h = fmul(st[k-1].z, FltHalf);
        end
        10: begin
          nx[k].c = fadd(st[k-1].c, FltC1);
          nx[k].s = fadd(st[k-1].s, FltS1);
        end
        11: begin
          nx[k].c = fmul(st[k-1].c, st[k-1].z);
          nx[k].s = fmul(st[k-1].s, st[k-1].z);
        end
        12: begin
          nx[k].c = fadd(st[k-1].c, FltC2);
          nx[k].s = fadd(st[k-1].s, FltS2);
        end
        13: begin
          nx[k].c = fmul(st[k-1].c, st[k-1].z);
          nx[k].s = fmul(st[k-1].s, st[k-1].z);
        end
        14: begin
          nx[k].c = fmul(st[k-1].c, st[k-1].z);
          nx[k].s = fmul(st[k-1].s, st[k-1].x);
        end
        15: begin
          nx[k].c = fsub(st[k-1].c, st[k-1].h);
          nx[k].s = fadd(st[k-1].s, st[k-1].x);
        end
        16: nx[k].c = fadd(st[k-1].c, FltOne);
        17: nx[k].c = (st[k-1].use_sin ? fadd(FltZero, st[k-1].s)
                                       : fadd(st[k-1].c, FltZero))
                      ^ {st[k-1].sgn, 31'd0};
        default: nx[k] = st[k-1];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= NumStages; k++) vld[k] <= 1'b0;
    end else if (ce) begin
      vld[0] <= s_axis_tvalid;
      for (int k = 1; k <= NumStages; k++) vld[k] <= vld[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      st[0] <= '{ovf: 1'b0, sgn: 1'b0, use_sin: 1'b0, j: 32'd0,
                 x: {1'b0, s_axis_tdata[30:0]}, y: 32'd0, z: 32'd0,
                 h: 32'd0, c: 32'd0, s: 32'd0};
      for (int k = 1; k <= NumStages; k++) st[k] <= nx[k];
    end
  end

endmodule
